>>> design/sfid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfid_pkg;

  // Largest number handed out, and the fixed width of the number fields.
  localparam int MAX_VALUE_DEF = 1024;
  localparam int NUM_W         = 11;

  // Request codes.
  localparam logic REQ_POP = 1'b0;
  localparam logic REQ_ADD = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic rd_num;   // read the bitmap word that holds the add-back number
    logic rd_sum;   // read the lowest bitmap word with a returned number
    logic emit_wm;  // issue the watermark or report exhaustion
    logic wr_add;   // set the add-back bit and write the word back
    logic wr_pop;   // clear the lowest set bit, write back, issue it
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_add;    // latched request is an add-back
    logic add_ok;    // add-back number lies in 1..watermark-1
    logic any_ret;   // at least one returned number is held
    logic out_free;  // output register can take a beat this cycle
  } sts_t;

endpackage

`default_nettype wire

>>> design/sfid_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sfid_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire sfid_pkg::sts_t sts_i,
  output sfid_pkg::cmd_t     cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_UPDATE
  } state_e;

  state_e state_q;
  state_e state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts_i.is_add) begin
          if (sts_i.add_ok) begin
            cmd_o.rd_num = 1'b1;
            state_d      = ST_UPDATE;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (sts_i.any_ret) begin
          cmd_o.rd_sum = 1'b1;
          state_d      = ST_UPDATE;
        end else if (sts_i.out_free) begin
          cmd_o.emit_wm = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_UPDATE: begin
        if (sts_i.is_add) begin
          cmd_o.wr_add = 1'b1;
          state_d      = ST_IDLE;
        end else if (sts_i.out_free) begin
          // A pop commits its write-back only once the result can be stored.
          cmd_o.wr_pop = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> design/sfid_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module sfid_dpath #(
  parameter int MAX_VALUE = sfid_pkg::MAX_VALUE_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      req_type_i,
  input  wire logic [sfid_pkg::NUM_W-1:0] number_i,
  input  wire logic                      out_stall_i,
  output logic                           out_valid_o,
  output logic [sfid_pkg::NUM_W-1:0]     value_o,
  output logic                           status_o,
  input  wire sfid_pkg::cmd_t            cmd_i,
  output sfid_pkg::sts_t                 sts_o
);

  localparam int NUM_W  = sfid_pkg::NUM_W;
  localparam int WM_W   = $clog2(MAX_VALUE + 2);
  localparam int LOG_W  = ($clog2(MAX_VALUE) + 1) / 2;
  localparam int WORD_W = 1 << LOG_W;
  localparam int NW     = (MAX_VALUE + WORD_W - 1) / WORD_W;
  localparam int AW     = (NW > 1) ? $clog2(NW) : 1;
  localparam int CMP_W  = (WM_W > NUM_W) ? WM_W : NUM_W;

  logic              req_q;
  logic [NUM_W-1:0]  num_q;
  logic [WM_W-1:0]   wm_q;
  logic [NW-1:0]     sum_q;
  logic [AW-1:0]     widx_q;
  logic [WORD_W-1:0] rd_q;
  logic [WORD_W-1:0] mem [NW];

  logic              out_valid_q;
  logic [NUM_W-1:0]  value_q;
  logic              status_q;

  logic              wm_ok;
  logic [WM_W-1:0]   num_m1;
  logic [AW-1:0]     add_idx;
  logic [LOG_W-1:0]  add_bit;
  logic [AW-1:0]     sum_idx;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] word_cur;
  logic [LOG_W-1:0]  pop_bit;
  logic [WORD_W-1:0] word_new;
  logic [WM_W-1:0]   pop_value;
  logic              rd_en;
  logic              wr_en;

  assign wm_ok = (wm_q <= WM_W'(MAX_VALUE));

  assign sts_o.is_add   = (req_q == sfid_pkg::REQ_ADD);
  assign sts_o.add_ok   = (num_q != '0) && (CMP_W'(num_q) < CMP_W'(wm_q));
  assign sts_o.any_ret  = |sum_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // An accepted add-back lies below the watermark, so num - 1 fits WM_W bits.
  assign num_m1  = WM_W'(num_q) - WM_W'(1);
  assign add_idx = AW'(num_m1 >> LOG_W);
  assign add_bit = num_m1[LOG_W-1:0];

  always_comb begin
    sum_idx = '0;
    for (int i = NW - 1; i >= 0; i--) begin
      if (sum_q[i]) begin
        sum_idx = AW'(i);
      end
    end
  end

  assign rd_addr = cmd_i.rd_num ? add_idx : sum_idx;
  assign rd_en   = cmd_i.rd_num || cmd_i.rd_sum;

  // A word whose summary bit is clear holds no returned number, whatever the
  // memory still contains from before reset.
  assign word_cur = sum_q[widx_q] ? rd_q : '0;

  always_comb begin
    pop_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (word_cur[i]) begin
        pop_bit = LOG_W'(i);
      end
    end
  end

  assign pop_value = WM_W'({widx_q, pop_bit}) + WM_W'(1);

  always_comb begin
    if (cmd_i.wr_add) begin
      word_new = word_cur | (WORD_W'(1) << add_bit);
    end else begin
      word_new = word_cur & ~(WORD_W'(1) << pop_bit);
    end
  end

  assign wr_en = cmd_i.wr_add || cmd_i.wr_pop;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[widx_q] <= word_new;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      num_q <= number_i;
    end
    if (rd_en) begin
      widx_q <= rd_addr;
    end
    if (cmd_i.emit_wm) begin
      if (wm_ok) begin
        value_q  <= NUM_W'(wm_q);
        status_q <= sfid_pkg::STATUS_OK;
      end else begin
        value_q  <= '0;
        status_q <= sfid_pkg::STATUS_EXHAUSTED;
      end
    end else if (cmd_i.wr_pop) begin
      value_q  <= NUM_W'(pop_value);
      status_q <= sfid_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm_q        <= WM_W'(1);
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit_wm && wm_ok) begin
        wm_q <= wm_q + WM_W'(1);
      end
      if (wr_en) begin
        sum_q[widx_q] <= (word_new != '0);
      end
      if (cmd_i.emit_wm || cmd_i.wr_pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

>>> design/smallest_free_id_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Smallest free ID allocator: a pop returns the smallest free number in
// 1..MAX_VALUE (value 0 with status 1 when none is left), and an add-back
// returns an issued number to the pool without producing a beat. Requests are
// handled one at a time: an add-back outside 1..watermark-1 is dropped, and an
// accepted one sets its bit in a read-modify-write of its bitmap word. A pop
// issues the watermark, or clears the lowest returned number's bit in a
// read-modify-write; it waits while the output register holds a stalled beat.
// The bitmap sits in a single-port word memory, addressed through a search
// of the per-word summary bits. The summary bits are cleared at reset and mask
// stale memory words, so requests are taken right after reset with no clearing pass.
module smallest_free_id_allocator_top #(
  parameter int MAX_VALUE = sfid_pkg::MAX_VALUE_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       req_type_i,
  input  wire logic [sfid_pkg::NUM_W-1:0] number_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [sfid_pkg::NUM_W-1:0]      value_o,
  output logic                            status_o
);

  sfid_pkg::cmd_t cmd;
  sfid_pkg::sts_t sts;

  sfid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfid_dpath #(
    .MAX_VALUE (MAX_VALUE)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_type_i  (req_type_i),
    .number_i    (number_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .value_o     (value_o),
    .status_o    (status_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

>>> design/sfid_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sfid_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_stall_o,
  input  wire logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  input  wire logic [sfid_pkg::NUM_W-1:0] value_o,
  input  wire logic                       status_o
);

  // A stalled output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(value_o) && $stable(status_o))
    else $error("output beat changed while stalled");

  // Exhaustion is always reported with value zero.
  a_exhaust_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == sfid_pkg::STATUS_EXHAUSTED) |-> value_o == '0)
    else $error("exhausted beat carries a nonzero value");

  // A successful pop never hands out zero.
  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == sfid_pkg::STATUS_OK) |-> value_o != '0)
    else $error("successful pop returned zero");

  // Requests are processed one at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a request was still in progress");

endmodule

bind smallest_free_id_allocator_top sfid_checker u_sfid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .value_o     (value_o),
  .status_o    (status_o)
);

`default_nettype wire
